>>> hw/rtl/bls_pkg.sv
// shared types and constants for the bresenham line stepper
`default_nettype none

package bls_pkg;

    // coordinate width and derived widths
    localparam int CW = 16;
    localparam int DW = CW + 1;
    localparam int EW = CW + 3;

    // operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // step direction codes
    localparam logic [1:0] DIR_ZERO = 2'b00;
    localparam logic [1:0] DIR_POS  = 2'b01;
    localparam logic [1:0] DIR_NEG  = 2'b11;

    // input beat
    typedef struct packed {
        logic                 op;
        logic signed [CW-1:0] start_x;
        logic signed [CW-1:0] start_y;
        logic signed [CW-1:0] end_x;
        logic signed [CW-1:0] end_y;
    } t_in_beat;

    // output beat
    typedef struct packed {
        logic signed [CW-1:0] cell_x;
        logic signed [CW-1:0] cell_y;
        logic                 last;
    } t_out_beat;

    // registered input item with its deltas already taken apart
    typedef struct packed {
        logic                 op;
        logic signed [CW-1:0] start_x;
        logic signed [CW-1:0] start_y;
        logic signed [CW-1:0] end_x;
        logic signed [CW-1:0] end_y;
        logic [CW-1:0]        abs_dx;
        logic [CW-1:0]        abs_dy;
        logic [1:0]           dir_x;
        logic [1:0]           dir_y;
    } t_prep;

    // stepper state seen by the top level
    typedef struct packed {
        logic signed [CW-1:0] cur_x;
        logic signed [CW-1:0] cur_y;
        logic                 at_goal;
    } t_bls_stat;

endpackage

`default_nettype wire

>>> hw/rtl/bls_prep.sv
// input register with delta, magnitude and direction setup
`default_nettype none

module bls_prep (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire bls_pkg::t_in_beat i_data,
    output logic                  o_stall,
    output logic                  o_valid,
    output bls_pkg::t_prep        o_prep,
    input  wire logic             i_take
);
    import bls_pkg::*;

    logic               r_valid;
    t_prep              r_prep;
    t_prep              n_prep;
    logic signed [CW:0] dx;
    logic signed [CW:0] dy;
    logic               accept;

    // signed deltas at one bit wider than a coordinate
    assign dx = {i_data.end_x[CW-1], i_data.end_x} - {i_data.start_x[CW-1], i_data.start_x};
    assign dy = {i_data.end_y[CW-1], i_data.end_y} - {i_data.start_y[CW-1], i_data.start_y};

    // magnitudes and directions
    always_comb begin
        n_prep.op      = i_data.op;
        n_prep.start_x = i_data.start_x;
        n_prep.start_y = i_data.start_y;
        n_prep.end_x   = i_data.end_x;
        n_prep.end_y   = i_data.end_y;
        n_prep.abs_dx  = dx[CW] ? CW'(-dx) : dx[CW-1:0];
        n_prep.abs_dy  = dy[CW] ? CW'(-dy) : dy[CW-1:0];
        n_prep.dir_x   = dx[CW] ? DIR_NEG : ((dx != '0) ? DIR_POS : DIR_ZERO);
        n_prep.dir_y   = dy[CW] ? DIR_NEG : ((dy != '0) ? DIR_POS : DIR_ZERO);
    end

    // hold a beat until the core takes it
    assign o_stall = r_valid && !i_take;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // payload register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prep <= n_prep;
        end
    end

    assign o_valid = r_valid;
    assign o_prep  = r_prep;

endmodule

`default_nettype wire

>>> hw/rtl/bls_core.sv
// line state, one step of the error update and the result register
`default_nettype none

module bls_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire bls_pkg::t_prep i_prep,
    output logic                o_take,
    output logic                o_out_valid,
    output bls_pkg::t_out_beat  o_out_data,
    input  wire logic           i_out_stall,
    output bls_pkg::t_bls_stat  o_stat
);
    import bls_pkg::*;

    logic signed [CW-1:0] r_cur_x, r_cur_y, r_goal_x, r_goal_y;
    logic signed [CW-1:0] n_cur_x, n_cur_y, n_goal_x, n_goal_y;
    logic [DW-1:0]        r_twice_dx, r_twice_dy, n_twice_dx, n_twice_dy;
    logic [1:0]           r_dir_x, r_dir_y, n_dir_x, n_dir_y;
    logic                 r_major_is_x, n_major_is_x;
    logic signed [EW-1:0] r_err, n_err;
    logic signed [EW-1:0] err_after;
    logic signed [EW-1:0] twice_maj, twice_min;
    logic [1:0]           dir_maj;
    logic                 maj_done;
    logic                 move_min;
    logic                 r_out_valid;
    t_out_beat            r_out;

    // core takes the held item whenever the result register frees up
    assign o_take = i_valid && (!r_out_valid || !i_out_stall);

    // major axis selection for a step
    assign twice_maj = r_major_is_x ? EW'(r_twice_dx) : EW'(r_twice_dy);
    assign twice_min = r_major_is_x ? EW'(r_twice_dy) : EW'(r_twice_dx);
    assign dir_maj   = r_major_is_x ? r_dir_x : r_dir_y;
    assign maj_done  = r_major_is_x ? (r_cur_x == r_goal_x) : (r_cur_y == r_goal_y);
    assign move_min  = !r_err[EW-1] && ((r_err != '0) || (dir_maj == DIR_POS));
    assign err_after = (move_min ? (r_err - twice_maj) : r_err) + twice_min;

    // next state for a start or a step
    always_comb begin
        n_cur_x      = r_cur_x;
        n_cur_y      = r_cur_y;
        n_goal_x     = r_goal_x;
        n_goal_y     = r_goal_y;
        n_twice_dx   = r_twice_dx;
        n_twice_dy   = r_twice_dy;
        n_dir_x      = r_dir_x;
        n_dir_y      = r_dir_y;
        n_major_is_x = r_major_is_x;
        n_err        = r_err;
        if (i_prep.op == OP_START) begin
            n_cur_x      = i_prep.start_x;
            n_cur_y      = i_prep.start_y;
            n_goal_x     = i_prep.end_x;
            n_goal_y     = i_prep.end_y;
            n_twice_dx   = {i_prep.abs_dx, 1'b0};
            n_twice_dy   = {i_prep.abs_dy, 1'b0};
            n_dir_x      = i_prep.dir_x;
            n_dir_y      = i_prep.dir_y;
            n_major_is_x = i_prep.abs_dx >= i_prep.abs_dy;
            if (i_prep.abs_dx >= i_prep.abs_dy) begin
                n_err = $signed({2'b00, i_prep.abs_dy, 1'b0}) - $signed({3'b000, i_prep.abs_dx});
            end else begin
                n_err = $signed({2'b00, i_prep.abs_dx, 1'b0}) - $signed({3'b000, i_prep.abs_dy});
            end
        end else if (!maj_done) begin
            n_err = err_after;
            if (r_major_is_x) begin
                n_cur_x = r_cur_x + {{(CW-2){r_dir_x[1]}}, r_dir_x};
                if (move_min) begin
                    n_cur_y = r_cur_y + {{(CW-2){r_dir_y[1]}}, r_dir_y};
                end
            end else begin
                n_cur_y = r_cur_y + {{(CW-2){r_dir_y[1]}}, r_dir_y};
                if (move_min) begin
                    n_cur_x = r_cur_x + {{(CW-2){r_dir_x[1]}}, r_dir_x};
                end
            end
        end
    end

    // line state, updated once per taken item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x      <= '0;
            r_cur_y      <= '0;
            r_goal_x     <= '0;
            r_goal_y     <= '0;
            r_twice_dx   <= '0;
            r_twice_dy   <= '0;
            r_dir_x      <= DIR_ZERO;
            r_dir_y      <= DIR_ZERO;
            r_major_is_x <= 1'b1;
            r_err        <= '0;
        end else if (o_take) begin
            r_cur_x      <= n_cur_x;
            r_cur_y      <= n_cur_y;
            r_goal_x     <= n_goal_x;
            r_goal_y     <= n_goal_y;
            r_twice_dx   <= n_twice_dx;
            r_twice_dy   <= n_twice_dy;
            r_dir_x      <= n_dir_x;
            r_dir_y      <= n_dir_y;
            r_major_is_x <= n_major_is_x;
            r_err        <= n_err;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out.cell_x <= n_cur_x;
            r_out.cell_y <= n_cur_y;
            r_out.last   <= (n_cur_x == n_goal_x) && (n_cur_y == n_goal_y);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;
    assign o_stat.cur_x   = r_cur_x;
    assign o_stat.cur_y   = r_cur_y;
    assign o_stat.at_goal = (r_cur_x == r_goal_x) && (r_cur_y == r_goal_y);

endmodule

`default_nettype wire

>>> hw/rtl/bresenham_line_stepper.sv
// top level of the bresenham line stepper
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+---------------------------------
//  in      | i_in_valid  | o_in_stall  | i_in_data  (op, start, end)
//  out     | o_out_valid | i_out_stall | o_out_data (cell_x, cell_y, last)
//
// one beat per cycle in, one beat per cycle out while the result is not stalled;
// a beat passes the input register, then the result register
// the throughput is set by the line-state loop: one error update per cycle when not stalled
// reset clears valids and puts the line at (0,0) to (0,0), x major
// a stalled result holds the line state; one more beat fits in the input register
`default_nettype none

module bresenham_line_stepper (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire bls_pkg::t_in_beat  i_in_data,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    output bls_pkg::t_out_beat      o_out_data,
    input  wire logic               i_out_stall
);
    import bls_pkg::*;

    logic      prep_valid;
    t_prep     prep;
    logic      take;
    t_bls_stat stat;

    // input register and delta setup
    bls_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_stall (o_in_stall),
        .o_valid (prep_valid),
        .o_prep  (prep),
        .i_take  (take)
    );

    // stepper state and result register
    bls_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (prep_valid),
        .i_prep      (prep),
        .o_take      (take),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .o_stat      (stat)
    );

    // input backs up only behind a stalled result
    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a stalled result");

    // last flag of the shown result tracks the line state
    a_last_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.last == stat.at_goal))
        else $error("result last flag disagrees with line state");

    // line state holds while a result is stalled
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(stat))
        else $error("line state moved under a stalled result");

endmodule

`default_nettype wire
